// ===== rtl/itb_pkg.sv =====
// shared types, constants and helpers for the balanced ternary converter
`timescale 1ns / 1ps

package itb_pkg;

    // default cap on digits per item
    localparam int MAX_TRITS_DEF = 10;

    // input word width
    localparam int VALUE_W = 32;

    // trit codes, two's complement in two bits
    localparam logic [1:0] TRIT_ZERO = 2'b00;
    localparam logic [1:0] TRIT_POS  = 2'b01;
    localparam logic [1:0] TRIT_NEG  = 2'b11;

    // remainder codes
    localparam logic [1:0] REM_ZERO = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;

    // multiplicative inverse of three modulo 2**32, exact division only
    localparam logic [VALUE_W-1:0] INV3 = 32'hAAAA_AAAB;

    // shift control for the digit chain
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

    // control for the divide-by-three unit
    typedef struct packed {
        logic load;
        logic reduce;
        logic divide;
    } div_ctrl_t;

    // status back from the divide-by-three unit
    typedef struct packed {
        logic [1:0] code;
        logic       rest_zero;
    } div_stat_t;

    // residue mod 3 of a 32-bit word: 4 = 1 mod 3, so base-4 digits add up
    function automatic logic [1:0] mod3(input logic [VALUE_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [1:0] r;
        s1 = '0;
        for (int i = 0; i < VALUE_W / 2; i++)
        begin
            s1 = s1 + 6'(x[2*i +: 2]);
        end
        s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
        unique case (s2)
            4'd0, 4'd3, 4'd6, 4'd9:   r = REM_ZERO;
            4'd1, 4'd4, 4'd7, 4'd10:  r = REM_ONE;
            4'd2, 4'd5, 4'd8, 4'd11:  r = REM_TWO;
            4'd12, 4'd15:             r = REM_ZERO;
            4'd13:                    r = REM_ONE;
            default:                  r = REM_TWO;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/integer_to_balanced_ternary.sv =====
// top level: signed integer in, balanced ternary digits out, most significant first
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   input   | in_valid / in_ready   | value (32-bit signed)
//   output  | out_valid / out_ready | trit (2-bit signed), last
//
// an item with n digits is accepted, then worked on, then sent out in n output
// beats; zero skips the work and goes straight to its one beat. the work is
// done by the shared divide-by-three unit, which alternates a reduce step and
// a multiply step.
// digits collect in a chain of cells and shift out from its head.
// a new item is taken only after the last digit of the previous one leaves.
// reset clears the control state; the chain and working registers need none.
`timescale 1ns / 1ps

module integer_to_balanced_ternary
    import itb_pkg::*;
#(
    parameter int MAX_TRITS = MAX_TRITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [1:0]         trit,
    output logic                      last
);

    localparam int CNT_W = $clog2(MAX_TRITS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;
    logic             is_zero;
    logic [1:0]       head_trit;
    cell_ctrl_t       cell_ctrl;
    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [1:0]       cell_q [MAX_TRITS];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign is_zero   = (value == '0);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cell_ctrl.push = 1'b0;
        cell_ctrl.pop  = 1'b0;
        div_ctrl       = '0;
        head_trit      = div_stat.code;
        unique case (state_reg)
            S_IDLE:
            begin
                head_trit = TRIT_ZERO;
                if (in_acc)
                begin
                    div_ctrl.load = 1'b1;
                    count_next    = '0;
                    if (is_zero)
                    begin
                        cell_ctrl.push = 1'b1;
                        count_next     = CNT_W'(1);
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                div_ctrl.reduce = 1'b1;
                cell_ctrl.push  = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                if (div_stat.rest_zero || count_next == CNT_W'(MAX_TRITS))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                div_ctrl.divide = 1'b1;
                state_next      = S_REDUCE;
            end
            S_EMIT:
            begin
                if (out_acc)
                begin
                    cell_ctrl.pop = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // shared divide-by-three unit
    itb_div3 u_div3 (
        .clk   (clk),
        .ctrl  (div_ctrl),
        .value (value),
        .stat  (div_stat)
    );

    // digit chain, head at cell 0
    for (genvar i = 0; i < MAX_TRITS; i++)
    begin : g_cell
        logic [1:0] prev_t;
        logic [1:0] next_t;
        if (i == 0)
        begin : g_head
            assign prev_t = head_trit;
        end
        else
        begin : g_body
            assign prev_t = cell_q[i-1];
        end
        if (i == MAX_TRITS - 1)
        begin : g_tail
            assign next_t = TRIT_ZERO;
        end
        else
        begin : g_mid
            assign next_t = cell_q[i+1];
        end
        itb_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .prev_trit (prev_t),
            .next_trit (next_t),
            .trit      (cell_q[i])
        );
    end

    assign trit = $signed(cell_q[0]);
    assign last = (count_reg == CNT_W'(1));

endmodule

// ===== rtl/itb_cell.sv =====
// one digit cell of the chain: shifts up on push, down on pop
`timescale 1ns / 1ps

module itb_cell
    import itb_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic [1:0] prev_trit,
    input  logic [1:0] next_trit,
    output logic [1:0] trit
);

    logic [1:0] trit_reg;
    logic [1:0] trit_next;

    // take from the lower neighbor on push, the upper one on pop
    always_comb
    begin
        trit_next = trit_reg;
        if (ctrl.push)
        begin
            trit_next = prev_trit;
        end
        else if (ctrl.pop)
        begin
            trit_next = next_trit;
        end
    end

    always_ff @(posedge clk)
    begin
        trit_reg <= trit_next;
    end

    assign trit = trit_reg;

endmodule

// ===== rtl/itb_div3.sv =====
// divide-by-three unit: one digit per reduce step, exact division per divide step
`timescale 1ns / 1ps

module itb_div3
    import itb_pkg::*;
(
    input  logic               clk,
    input  div_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] value,
    output div_stat_t          stat
);

    logic [VALUE_W-1:0] u_reg;
    logic [VALUE_W-1:0] u_next;
    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] x_next;
    logic               neg_reg;
    logic               neg_next;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] prod;
    logic [1:0]         rem;
    logic [1:0]         base_code;

    // magnitude of the input, most negative value maps to 2**31
    assign mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

    assign rem  = mod3(u_reg);
    assign prod = x_reg * INV3;

    // digit of the magnitude, then flip it for a negative item
    always_comb
    begin
        unique case (rem)
            REM_ZERO: base_code = TRIT_ZERO;
            REM_ONE:  base_code = TRIT_POS;
            default:  base_code = TRIT_NEG;
        endcase
    end

    always_comb
    begin
        stat.code = base_code;
        if (neg_reg && base_code == TRIT_POS)
        begin
            stat.code = TRIT_NEG;
        end
        else if (neg_reg && base_code == TRIT_NEG)
        begin
            stat.code = TRIT_POS;
        end
        // only a magnitude of one leaves nothing after the digit is removed
        stat.rest_zero = (u_reg == VALUE_W'(1));
    end

    // next values of the working registers
    always_comb
    begin
        u_next   = u_reg;
        x_next   = x_reg;
        neg_next = neg_reg;
        if (ctrl.load)
        begin
            u_next   = mag;
            neg_next = value[VALUE_W-1];
        end
        else if (ctrl.divide)
        begin
            u_next = prod;
        end
        if (ctrl.reduce)
        begin
            unique case (rem)
                REM_ZERO: x_next = u_reg;
                REM_ONE:  x_next = u_reg - VALUE_W'(1);
                default:  x_next = u_reg + VALUE_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        x_reg   <= x_next;
        neg_reg <= neg_next;
    end

endmodule
